/* rtl/bmorph_pkg.sv */
package bmorph_pkg;

    // Frame size limits and the widths that follow from them.
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int PIX_W       = 8;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int WIDTH_CW    = COL_W + 1;
    localparam int HEIGHT_CW   = ROW_W + 1;
    localparam int CFG_DATA_W  = HEIGHT_CW;
    localparam int CFG_INDEX_W = 2;
    localparam int MODE_W      = 2;
    localparam int STORE_W     = 2 * PIX_W;
    localparam int WIN_SIDE    = 3;
    localparam int WIN_SIZE    = WIN_SIDE * WIN_SIDE;
    localparam int WIN_IDX_W   = $clog2(WIN_SIZE);
    localparam int NUM_CAND    = 4;

    localparam logic [PIX_W-1:0] WHITE = '1;
    localparam logic [PIX_W-1:0] BLACK = '0;

    // Operation codes held in the mode register.
    localparam logic [MODE_W-1:0] MODE_ERODE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DILATE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INTERIOR = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 2'd2;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [WIN_SIZE-1:0][PIX_W-1:0] window_t;

    // Which window position is the centre, and which window rows and
    // columns lie inside the frame.
    typedef struct packed {
        logic                row_hi;
        logic                col_hi;
        logic [WIN_SIDE-1:0] row_ok;
        logic [WIN_SIDE-1:0] col_ok;
    } eval_sel_t;

endpackage

/* rtl/binary_morphology_3x3.sv */
// 3x3 binary morphology (erode, dilate, interior removal) on a raster pixel
// stream. Each accepted pixel is written to a 1024 x 16 row store (the two
// previous rows side by side, registered read) and shifted into a 3x3 window;
// the result for a pixel leaves one row and one column later, tagged with its
// row and column, via the input stage, window stage and output register.
// One shared evaluator feeds the output register with one result per cycle
// unless out_stall holds it, so the block takes one pixel per cycle while each
// pixel gives at most one result; a pixel in the last column or on the last
// row gives up to two results and the frame's final pixel up to four, and the
// input waits until all but the last are emitted. Writing the width or height
// register restarts the frame at row 0, column 0; configuration must only be
// written while the block is idle. Out-of-range sizes are clamped to 1 .. 1024
// columns and 1 .. 4096 rows.
module binary_morphology_3x3 (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_write,
    input  logic [bmorph_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bmorph_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [bmorph_pkg::PIX_W-1:0]         pixel_in,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [bmorph_pkg::PIX_W-1:0]         pixel_out,
    output logic [bmorph_pkg::ROW_W-1:0]         out_row,
    output logic [bmorph_pkg::COL_W-1:0]         out_column,
    output logic                                 last_of_run,
    output logic                                 end_of_frame
);

    // Configuration registers.
    logic [bmorph_pkg::MODE_W-1:0]     mode_reg;
    logic [bmorph_pkg::WIDTH_CW-1:0]   width_reg;
    logic [bmorph_pkg::HEIGHT_CW-1:0]  height_reg;
    logic [bmorph_pkg::WIDTH_CW-1:0]   w_eff;
    logic [bmorph_pkg::HEIGHT_CW-1:0]  h_eff;
    logic                              size_write;

    // Raster position of the next pixel.
    logic [bmorph_pkg::COL_W-1:0]      col_reg;
    logic [bmorph_pkg::COL_W-1:0]      col_next;
    logic [bmorph_pkg::ROW_W-1:0]      row_reg;
    logic [bmorph_pkg::ROW_W-1:0]      row_next;
    logic [bmorph_pkg::WIDTH_CW-1:0]   col_plus;
    logic [bmorph_pkg::HEIGHT_CW-1:0]  row_plus;
    logic                              last_col;
    logic                              last_row;
    logic                              in_accept;

    // Row store access.
    logic [bmorph_pkg::STORE_W-1:0]    store_rdata;
    logic [bmorph_pkg::STORE_W-1:0]    store_wdata;
    logic [bmorph_pkg::STORE_W-1:0]    store_word;
    logic                              fwd_hit_reg;
    logic [bmorph_pkg::STORE_W-1:0]    fwd_data_reg;

    // Input stage.
    logic                              s1_valid_reg;
    logic                              s1_valid_next;
    bmorph_pkg::pix_t                  s1_pix_reg;
    logic [bmorph_pkg::ROW_W-1:0]      s1_row_reg;
    logic [bmorph_pkg::COL_W-1:0]      s1_col_reg;
    logic                              s1_last_col_reg;
    logic                              s1_last_row_reg;
    logic                              s1_advance;
    logic [bmorph_pkg::NUM_CAND-1:0]   new_mask;

    // Window and result stage.
    bmorph_pkg::window_t               win_reg;
    bmorph_pkg::window_t               win_next;
    logic [bmorph_pkg::NUM_CAND-1:0]   pend_reg;
    logic [bmorph_pkg::NUM_CAND-1:0]   pend_next;
    logic [bmorph_pkg::ROW_W-1:0]      s2_row_reg;
    logic [bmorph_pkg::COL_W-1:0]      s2_col_reg;
    logic [bmorph_pkg::NUM_CAND-1:0]   cand_hot;
    logic [bmorph_pkg::NUM_CAND-1:0]   cand_rest;
    bmorph_pkg::eval_sel_t             cand_sel;
    bmorph_pkg::pix_t                  cand_pixel;
    logic                              emit;
    logic                              s2_free;

    // Output register.
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              out_free;
    bmorph_pkg::pix_t                  out_pixel_reg;
    logic [bmorph_pkg::ROW_W-1:0]      out_row_reg;
    logic [bmorph_pkg::COL_W-1:0]      out_col_reg;
    logic                              out_last_reg;
    logic                              out_eof_reg;

    // Clamp the frame size to the supported range.
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = bmorph_pkg::WIDTH_CW'(1);
        end
        else if (width_reg > bmorph_pkg::WIDTH_CW'(bmorph_pkg::MAX_WIDTH))
        begin
            w_eff = bmorph_pkg::WIDTH_CW'(bmorph_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end

        if (height_reg == '0)
        begin
            h_eff = bmorph_pkg::HEIGHT_CW'(1);
        end
        else if (height_reg > bmorph_pkg::HEIGHT_CW'(bmorph_pkg::MAX_HEIGHT))
        begin
            h_eff = bmorph_pkg::HEIGHT_CW'(bmorph_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    assign size_write = cfg_write &&
                        (cfg_index == bmorph_pkg::CFG_WIDTH ||
                         cfg_index == bmorph_pkg::CFG_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= bmorph_pkg::MODE_ERODE;
            width_reg  <= bmorph_pkg::WIDTH_CW'(640);
            height_reg <= bmorph_pkg::HEIGHT_CW'(480);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bmorph_pkg::CFG_MODE:   mode_reg   <= cfg_data[bmorph_pkg::MODE_W-1:0];
                bmorph_pkg::CFG_WIDTH:  width_reg  <= cfg_data[bmorph_pkg::WIDTH_CW-1:0];
                bmorph_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Raster counters advance on every input transfer.
    assign in_accept = in_valid && !in_stall;
    assign col_plus  = {1'b0, col_reg} + 1'b1;
    assign row_plus  = {1'b0, row_reg} + 1'b1;
    assign last_col  = col_plus >= w_eff;
    assign last_row  = row_plus >= h_eff;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (size_write)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_plus[bmorph_pkg::ROW_W-1:0];
            end
            else
            begin
                col_next = col_plus[bmorph_pkg::COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Row store: upper byte is the older row, lower byte the previous row.
    // The read is issued on the input transfer, the write when the item
    // leaves the input stage.
    bmorph_ram #(
        .WIDTH (bmorph_pkg::STORE_W),
        .DEPTH (bmorph_pkg::MAX_WIDTH)
    ) u_row_store (
        .clk     (clk),
        .wr_en   (s1_advance),
        .wr_addr (s1_col_reg),
        .wr_data (store_wdata),
        .rd_en   (in_accept),
        .rd_addr (col_reg),
        .rd_data (store_rdata)
    );

    // With a one-pixel row the next item reads the entry written in the same
    // cycle, so that word is forwarded.
    assign store_word  = fwd_hit_reg ? fwd_data_reg : store_rdata;
    assign store_wdata = {store_word[bmorph_pkg::PIX_W-1:0], s1_pix_reg};

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            fwd_hit_reg     <= s1_advance && (s1_col_reg == col_reg);
            fwd_data_reg    <= store_wdata;
            s1_pix_reg      <= pixel_in;
            s1_row_reg      <= row_reg;
            s1_col_reg      <= col_reg;
            s1_last_col_reg <= last_col;
            s1_last_row_reg <= last_row;
        end
    end

    // Input stage occupancy.
    assign in_stall   = s1_valid_reg && !s2_free;
    assign s1_advance = s1_valid_reg && s2_free;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Results this pixel releases: the interior center, the row's last
    // column, the last row, and the frame's final pixel.
    assign new_mask[0] = (s1_row_reg != '0) && (s1_col_reg != '0);
    assign new_mask[1] = (s1_row_reg != '0) && s1_last_col_reg;
    assign new_mask[2] = s1_last_row_reg && (s1_col_reg != '0);
    assign new_mask[3] = s1_last_row_reg && s1_last_col_reg;

    // Shift the window left and load the new column.
    always_comb
    begin
        win_next = win_reg;
        if (s1_advance)
        begin
            for (int i = 0; i < bmorph_pkg::WIN_SIZE - bmorph_pkg::WIN_SIDE; i++)
            begin
                win_next[i] = win_reg[i + bmorph_pkg::WIN_SIDE];
            end
            win_next[6] = store_word[bmorph_pkg::STORE_W-1:bmorph_pkg::PIX_W];
            win_next[7] = store_word[bmorph_pkg::PIX_W-1:0];
            win_next[8] = s1_pix_reg;
        end
    end

    // Pick the lowest pending result and evaluate it.
    assign cand_hot  = pend_reg & (~pend_reg + 4'd1);
    assign cand_rest = pend_reg & ~cand_hot;

    always_comb
    begin
        cand_sel.row_hi = cand_hot[2] | cand_hot[3];
        cand_sel.col_hi = cand_hot[1] | cand_hot[3];
        cand_sel.row_ok = {1'b1, s2_row_reg != '0,
                           |s2_row_reg[bmorph_pkg::ROW_W-1:1]};
        cand_sel.col_ok = {1'b1, s2_col_reg != '0,
                           |s2_col_reg[bmorph_pkg::COL_W-1:1]};
    end

    bmorph_eval u_eval (
        .win   (win_reg),
        .sel   (cand_sel),
        .mode  (mode_reg),
        .pixel (cand_pixel)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = (pend_reg != '0) && out_free;
    assign s2_free  = (pend_reg == '0) || ((cand_rest == '0) && out_free);

    always_comb
    begin
        pend_next = pend_reg;
        if (s1_advance)
        begin
            pend_next = new_mask;
        end
        else if (emit)
        begin
            pend_next = cand_rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            win_reg  <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            win_reg  <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            s2_row_reg <= s1_row_reg;
            s2_col_reg <= s1_col_reg;
        end
    end

    // Output register: one result per transfer.
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_pixel_reg <= cand_pixel;
            out_row_reg   <= cand_sel.row_hi ? s2_row_reg : s2_row_reg - 1'b1;
            out_col_reg   <= cand_sel.col_hi ? s2_col_reg : s2_col_reg - 1'b1;
            out_last_reg  <= (cand_rest == '0);
            out_eof_reg   <= cand_hot[3];
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_out    = out_pixel_reg;
    assign out_row      = out_row_reg;
    assign out_column   = out_col_reg;
    assign last_of_run  = out_last_reg;
    assign end_of_frame = out_eof_reg;

    // The raster counters always stay inside the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, col_reg} < w_eff) && ({1'b0, row_reg} < h_eff))
    else $error("raster position outside the frame");

    // A held result is never overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !emit)
    else $error("result overwritten while stalled");

    // The frame's final result always closes its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_eof_reg) |-> out_last_reg)
    else $error("end of frame without last of run");

    // A pixel that releases results leaves them pending in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && (new_mask != '0)) |=> (pend_reg != '0))
    else $error("released results were lost");

    // The input stage only waits on a busy result stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |-> (pend_reg != '0))
    else $error("input stage stalled with an empty result stage");

endmodule

/* rtl/bmorph_ram.sv */
module bmorph_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/bmorph_eval.sv */
module bmorph_eval (
    input  bmorph_pkg::window_t            win,
    input  bmorph_pkg::eval_sel_t          sel,
    input  logic [bmorph_pkg::MODE_W-1:0]  mode,
    output bmorph_pkg::pix_t               pixel
);

    logic [bmorph_pkg::WIN_IDX_W-1:0] ctr_idx;
    bmorph_pkg::pix_t                 centre;
    bmorph_pkg::pix_t                 hi;
    bmorph_pkg::pix_t                 lo;
    logic                             all_zero;

    // The center sits at window row 1 or 2 and column 1 or 2.
    assign ctr_idx = 4'd4 + (sel.col_hi ? 4'd3 : 4'd0) + {3'd0, sel.row_hi};
    assign centre  = win[ctr_idx];

    // Maximum, minimum and all-black test over the in-frame neighbors.
    // Row and column 0 fall outside the neighborhood when the center is at 2.
    always_comb
    begin
        hi       = bmorph_pkg::BLACK;
        lo       = bmorph_pkg::WHITE;
        all_zero = 1'b1;
        for (int c = 0; c < bmorph_pkg::WIN_SIDE; c++)
        begin
            for (int r = 0; r < bmorph_pkg::WIN_SIDE; r++)
            begin
                if (sel.row_ok[r] && !(sel.row_hi && r == 0) &&
                    sel.col_ok[c] && !(sel.col_hi && c == 0))
                begin
                    if (win[c * bmorph_pkg::WIN_SIDE + r] > hi)
                    begin
                        hi = win[c * bmorph_pkg::WIN_SIDE + r];
                    end
                    if (win[c * bmorph_pkg::WIN_SIDE + r] < lo)
                    begin
                        lo = win[c * bmorph_pkg::WIN_SIDE + r];
                    end
                    if (win[c * bmorph_pkg::WIN_SIDE + r] != bmorph_pkg::BLACK)
                    begin
                        all_zero = 1'b0;
                    end
                end
            end
        end
    end

    // Operation select; the unused code passes the center through.
    always_comb
    begin
        case (mode)
            bmorph_pkg::MODE_ERODE:
                pixel = (centre == bmorph_pkg::BLACK) ? hi : bmorph_pkg::WHITE;
            bmorph_pkg::MODE_DILATE:
                pixel = (centre != bmorph_pkg::BLACK) ? lo : bmorph_pkg::BLACK;
            bmorph_pkg::MODE_INTERIOR:
                pixel = (centre == bmorph_pkg::BLACK && all_zero) ?
                        bmorph_pkg::WHITE : centre;
            default:
                pixel = centre;
        endcase
    end

endmodule

/* verif/tb.sv */
module tb;
    import bmorph_pkg::*;

    // The spare mode code passes the centre through; the spare index selects no register.
    localparam logic [MODE_W-1:0]      MODE_PASS     = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE     = 2'd3;
    localparam int                     SETTLE_CYCLES = 12;
    localparam int                     WIDE_ITEMS    = 64;
    localparam int                     RANDOM_ITEMS  = 330;
    localparam int                     CALM_ITEMS    = 60;
    localparam int                     FEED_CAP      = 96;
    localparam int                     PLAN_LEN      = 35;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [PIX_W-1:0]       pixel_in;
    logic                   out_valid;
    logic                   out_stall;
    logic [PIX_W-1:0]       pixel_out;
    logic [ROW_W-1:0]       out_row;
    logic [COL_W-1:0]       out_column;
    logic                   last_of_run;
    logic                   end_of_frame;

    binary_morphology_3x3 u_top (.*);

    typedef struct packed {
        pix_t             pix;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic             last;
        logic             eof;
    } morph_result_t;

    typedef enum logic {STEP_CFG, STEP_PIXEL} step_kind_t;

    typedef struct packed {
        step_kind_t             kind;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  value;
        pix_t                   pix;
        logic                   typed;
        pix_t                   typed_pix;
    } plan_row_t;

    // Directed stimulus. Single-pixel frames carry their result typed in;
    // the larger frames are checked against the window predictor.
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        '{STEP_CFG,   CFG_WIDTH,  13'd0,                 BLACK,  1'b0, BLACK},
        '{STEP_CFG,   CFG_HEIGHT, 13'd0,                 BLACK,  1'b0, BLACK},
        '{STEP_CFG,   CFG_SPARE,  13'd8191,              BLACK,  1'b0, BLACK},
        '{STEP_CFG,   CFG_MODE,   {11'd0, MODE_ERODE},   BLACK,  1'b0, BLACK},
        '{STEP_PIXEL, CFG_MODE,   13'd0,                 BLACK,  1'b1, BLACK},
        '{STEP_PIXEL, CFG_MODE,   13'd0,                 WHITE,  1'b1, WHITE},
        '{STEP_PIXEL, CFG_MODE,   13'd0,                 8'd1,   1'b1, WHITE},
        '{STEP_CFG,   CFG_MODE,   {11'd0, MODE_DILATE},  BLACK,  1'b0, BLACK},
        '{STEP_PIXEL, CFG_MODE,   13'd0,                 BLACK,  1'b1, BLACK},
        '{STEP_PIXEL, CFG_MODE,   13'd0,                 WHITE,  1'b1, WHITE},
        '{STEP_PIXEL, CFG_MODE,   13'd0,                 8'd128, 1'b1, 8'd128},
        '{STEP_CFG,   CFG_MODE,   {11'd0, MODE_INTERIOR}, BLACK, 1'b0, BLACK},
        '{STEP_PIXEL, CFG_MODE,   13'd0,                 BLACK,  1'b1, WHITE},
        '{STEP_PIXEL, CFG_MODE,   13'd0,                 8'd85,  1'b1, 8'd85},
        '{STEP_CFG,   CFG_MODE,   {11'd0, MODE_PASS},    BLACK,  1'b0, BLACK},
        '{STEP_PIXEL, CFG_MODE,   13'd0,                 8'd170, 1'b1, 8'd170},
        '{STEP_CFG,   CFG_WIDTH,  13'd3,                 BLACK,  1'b0, BLACK},
        '{STEP_CFG,   CFG_HEIGHT, 13'd3,                 BLACK,  1'b0, BLACK},
        '{STEP_CFG,   CFG_MODE,   {11'd0, MODE_ERODE},   BLACK,  1'b0, BLACK},
        '{STEP_PIXEL, CFG_MODE,   13'd0,                 BLACK,  1'b0, BLACK},
        '{STEP_PIXEL, CFG_MODE,   13'd0,                 BLACK,  1'b0, BLACK},
        '{STEP_PIXEL, CFG_MODE,   13'd0,                 BLACK,  1'b0, BLACK},
        '{STEP_PIXEL, CFG_MODE,   13'd0,                 BLACK,  1'b0, BLACK},
        '{STEP_PIXEL, CFG_MODE,   13'd0,                 BLACK,  1'b0, BLACK},
        '{STEP_PIXEL, CFG_MODE,   13'd0,                 BLACK,  1'b0, BLACK},
        '{STEP_PIXEL, CFG_MODE,   13'd0,                 BLACK,  1'b0, BLACK},
        '{STEP_PIXEL, CFG_MODE,   13'd0,                 BLACK,  1'b0, BLACK},
        '{STEP_PIXEL, CFG_MODE,   13'd0,                 WHITE,  1'b0, BLACK},
        '{STEP_CFG,   CFG_WIDTH,  13'd2,                 BLACK,  1'b0, BLACK},
        '{STEP_CFG,   CFG_HEIGHT, 13'd8191,              BLACK,  1'b0, BLACK},
        '{STEP_CFG,   CFG_MODE,   {11'd0, MODE_DILATE},  BLACK,  1'b0, BLACK},
        '{STEP_PIXEL, CFG_MODE,   13'd0,                 WHITE,  1'b0, BLACK},
        '{STEP_PIXEL, CFG_MODE,   13'd0,                 BLACK,  1'b0, BLACK},
        '{STEP_PIXEL, CFG_MODE,   13'd0,                 WHITE,  1'b0, BLACK},
        '{STEP_PIXEL, CFG_MODE,   13'd0,                 WHITE,  1'b0, BLACK}
    };

    morph_result_t results_due [$];
    int            mismatches = 0;
    bit            calm = 1'b0;

    // Shadow of the block: two row stores, the 3x3 window, counters, registers.
    pix_t                  older_row [MAX_WIDTH];
    pix_t                  prev_row  [MAX_WIDTH];
    pix_t                  win       [WIN_SIZE];
    int unsigned           col_at;
    int unsigned           row_at;
    logic [MODE_W-1:0]     op_mode    = MODE_ERODE;
    logic [WIDTH_CW-1:0]   width_reg  = 11'd640;
    logic [HEIGHT_CW-1:0]  height_reg = 13'd480;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int unsigned frame_cols();
        if (width_reg == 0)
            return 1;
        return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    endfunction

    function automatic int unsigned frame_rows();
        if (height_reg == 0)
            return 1;
        return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    endfunction

    // Applies the current operation to the centre at window row cr, column cc,
    // looking only at window rows and columns that lie inside the frame.
    function automatic pix_t window_result(int cr, int cc, logic [2:0] row_ok,
                                           logic [2:0] col_ok);
        pix_t centre;
        pix_t hi;
        pix_t lo;
        pix_t v;
        bit   all_black;
        int   r;
        int   c;
        centre    = win[cc * 3 + cr];
        hi        = BLACK;
        lo        = WHITE;
        all_black = 1'b1;
        for (r = cr - 1; r <= cr + 1; r++)
        begin
            if (r >= 0 && r <= 2)
            begin
                for (c = cc - 1; c <= cc + 1; c++)
                begin
                    if (c >= 0 && c <= 2)
                    begin
                        if (row_ok[r] && col_ok[c])
                        begin
                            v = win[c * 3 + r];
                            if (v > hi)
                                hi = v;
                            if (v < lo)
                                lo = v;
                            if (v != BLACK)
                                all_black = 1'b0;
                        end
                    end
                end
            end
        end
        case (op_mode)
            MODE_ERODE:    return (centre == BLACK) ? hi : WHITE;
            MODE_DILATE:   return (centre != BLACK) ? lo : BLACK;
            MODE_INTERIOR: return (centre == BLACK && all_black) ? WHITE : centre;
            default:       return centre;
        endcase
    endfunction

    function automatic morph_result_t make_result(pix_t p, int unsigned r, int unsigned c,
                                                  bit last, bit eof);
        morph_result_t res;
        res.pix    = p;
        res.row    = r[ROW_W-1:0];
        res.column = c[COL_W-1:0];
        res.last   = last;
        res.eof    = eof;
        return res;
    endfunction

    // Shifts one pixel into the window and row stores and returns the results
    // whose neighborhoods it completes, in output order.
    function automatic int morph_step(input pix_t px, output morph_result_t res [NUM_CAND]);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned idx;
        logic [2:0]  row_ok;
        logic [2:0]  col_ok;
        bit          last_col;
        bit          last_row;
        int          n;
        int          i;
        w        = frame_cols();
        h        = frame_rows();
        c        = col_at;
        r        = row_at;
        idx      = c % MAX_WIDTH;
        last_col = (c + 1 == w);
        last_row = (r + 1 == h);
        n        = 0;

        for (i = 0; i < 6; i++)
            win[i] = win[i + 3];
        win[6]         = older_row[idx];
        win[7]         = prev_row[idx];
        win[8]         = px;
        older_row[idx] = prev_row[idx];
        prev_row[idx]  = px;

        row_ok = {1'b1, r >= 1, r >= 2};
        col_ok = {1'b1, c >= 1, c >= 2};

        if (r >= 1 && c >= 1)
        begin
            res[n] = make_result(window_result(1, 1, row_ok, col_ok), r - 1, c - 1,
                                 1'b0, 1'b0);
            n++;
        end
        if (r >= 1 && last_col)
        begin
            res[n] = make_result(window_result(1, 2, row_ok, col_ok), r - 1, c,
                                 1'b0, 1'b0);
            n++;
        end
        if (last_row && c >= 1)
        begin
            res[n] = make_result(window_result(2, 1, row_ok, col_ok), r, c - 1,
                                 1'b0, 1'b0);
            n++;
        end
        if (last_row && last_col)
        begin
            res[n] = make_result(window_result(2, 2, row_ok, col_ok), r, c,
                                 1'b0, 1'b1);
            n++;
        end
        if (n > 0)
            res[n - 1].last = 1'b1;

        if (c + 1 >= w)
        begin
            col_at = 0;
            row_at = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_at = c + 1;
        end
        return n;
    endfunction

    // Mostly black and white, as a binary image would be, with some gray.
    function automatic pix_t rand_pixel();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return BLACK;
        if (pick < 7)
            return WHITE;
        return pix_t'($urandom_range(0, 255));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_width();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return CFG_DATA_W'($urandom_range(9, 16));
            default: return CFG_DATA_W'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_height();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return CFG_DATA_W'($urandom_range(MAX_HEIGHT + 1, 8191));
            default: return CFG_DATA_W'($urandom_range(1, 5));
        endcase
    endfunction

    // One pixel transfer, with an optional gap in front of it.
    task automatic send_pixel(input pix_t px, input bit typed, input pix_t typed_pix);
        morph_result_t res [NUM_CAND];
        int            n;
        int            i;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= px;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n = morph_step(px, res);
        if (typed)
        begin
            results_due.push_back(make_result(typed_pix, 0, 0, 1'b1, 1'b1));
        end
        else
        begin
            for (i = 0; i < n; i++)
                results_due.push_back(res[i]);
        end
    endtask

    // Register write once the block has drained.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (index)
            CFG_MODE:
                op_mode = value[MODE_W-1:0];
            CFG_WIDTH:
            begin
                width_reg = value[WIDTH_CW-1:0];
                col_at    = 0;
                row_at    = 0;
            end
            CFG_HEIGHT:
            begin
                height_reg = value[HEIGHT_CW-1:0];
                col_at     = 0;
                row_at     = 0;
            end
            default:
                ;
        endcase
    endtask

    // Stimulus: directed table, a run along a wide row, then random phases.
    initial
    begin
        plan_row_t   step;
        int          rand_items;
        int unsigned frame;
        int unsigned feed;
        int          k;
        int unsigned j;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_MODE;
        cfg_data  = '0;
        in_valid  = 1'b0;
        pixel_in  = BLACK;
        col_at    = 0;
        row_at    = 0;
        foreach (win[i])
            win[i] = BLACK;
        foreach (older_row[i])
        begin
            older_row[i] = BLACK;
            prev_row[i]  = BLACK;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < PLAN_LEN; k++)
        begin
            step = PLAN[k];
            if (step.kind == STEP_CFG)
                write_reg(step.index, step.value);
            else
                send_pixel(step.pix, step.typed, step.typed_pix);
        end

        // Width written above range acts as the widest frame: a run along
        // the first row of a single-row frame.
        write_reg(CFG_MODE, {11'd0, MODE_ERODE});
        write_reg(CFG_WIDTH, '1);
        write_reg(CFG_HEIGHT, 13'd1);
        for (k = 0; k < WIDE_ITEMS; k++)
            send_pixel(rand_pixel(), 1'b0, BLACK);

        // Mostly whole frames with random content; some cut short by a
        // size write, some continued across a mode change.
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_MODE, CFG_DATA_W'($urandom_range(0, 3)));
            if ($urandom_range(0, 15) == 0)
                write_reg(CFG_SPARE, CFG_DATA_W'($urandom()));
            if ($urandom_range(0, 3) != 0)
            begin
                write_reg(CFG_WIDTH, pick_width());
                write_reg(CFG_HEIGHT, pick_height());
            end
            frame = frame_cols() * frame_rows();
            if ($urandom_range(0, 3) != 0)
                feed = frame * $urandom_range(1, 2);
            else
                feed = $urandom_range(1, (frame > FEED_CAP) ? FEED_CAP : frame);
            if (feed > FEED_CAP)
                feed = $urandom_range(1, FEED_CAP);
            for (j = 0; j < feed; j++)
            begin
                calm = (rand_items >= RANDOM_ITEMS - CALM_ITEMS);
                send_pixel(rand_pixel(), 1'b0, BLACK);
                rand_items++;
            end
        end

        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Output back-pressure in random bursts.
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Every output transfer is matched against the oldest predicted result.
    always @(posedge clk)
    begin
        morph_result_t got;
        morph_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {pixel_out, out_row, out_column, last_of_run, end_of_frame};
            if (results_due.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, got pixel %0d row %0d col %0d",
                         $time, got.pix, got.row, got.column);
                mismatches++;
            end
            else
            begin
                want = results_due.pop_front();
                check_field("pixel_out", want.pix, got.pix);
                check_field("out_row", want.row, got.row);
                check_field("out_column", want.column, got.column);
                check_field("last_of_run", want.last, got.last);
                check_field("end_of_frame", want.eof, got.eof);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
